// ===== design/awt_pkg.sv =====
// ----------------------------------------------------------------------------
// awt_pkg
// Shared types and constants of the selective-repeat send window tracker.
// ----------------------------------------------------------------------------
package awt_pkg;

  localparam int unsigned WindowSlotsDef = 16;
  localparam int unsigned MaxSegmentDef  = 1000;
  localparam int unsigned MaxOut         = 16;
  localparam int unsigned OutCntW        = 5;
  localparam logic [15:0] ResendReset    = 16'd200;

  typedef enum logic [2:0] {
    REQ_ENQ  = 3'd0,
    REQ_ACK  = 3'd1,
    REQ_BAD  = 3'd2,
    REQ_TICK = 3'd3,
    REQ_SCAN = 3'd4
  } awt_req_e;

  typedef enum logic [1:0] {
    RESP_ACCEPT = 2'd0,
    RESP_REFUSE = 2'd1,
    RESP_TX     = 2'd2
  } awt_resp_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_WAIT  = 2'd1,
    ST_SENT  = 2'd2,
    ST_ACKED = 2'd3
  } awt_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RET_RD,
    S_RET_EV,
    S_SCAN_RD,
    S_SCAN_EV,
    S_FLUSH
  } awt_state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] serial;
    logic [9:0]  seg_size;
  } awt_in_t;

  typedef struct packed {
    logic [1:0]  resp_kind;
    logic [31:0] out_serial;
    logic [9:0]  out_size;
    logic        last;
  } awt_out_t;

  typedef struct packed {
    logic [9:0]  size;
    logic [31:0] stamp;
  } awt_data_t;

  typedef struct packed {
    awt_status_e status;
    awt_data_t   data;
  } awt_slot_t;

endpackage

// ===== design/awt_slot_store.sv =====
// ----------------------------------------------------------------------------
// awt_slot_store
// Per-slot status and segment data memories, registered read.
// ----------------------------------------------------------------------------
module awt_slot_store #(
  parameter int unsigned WINDOW_SLOTS = awt_pkg::WindowSlotsDef,
  parameter int unsigned SLOT_W       = $clog2(WINDOW_SLOTS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [SLOT_W-1:0]       addr_i,
  input  logic                    rd_en_i,
  input  logic                    st_we_i,
  input  awt_pkg::awt_status_e    st_wdata_i,
  input  logic                    dat_we_i,
  input  awt_pkg::awt_data_t      dat_wdata_i,
  output awt_pkg::awt_slot_t      rd_o
);
  import awt_pkg::*;

  awt_status_e st_mem  [WINDOW_SLOTS];
  awt_data_t   dat_mem [WINDOW_SLOTS];
  logic [WINDOW_SLOTS-1:0] vld_q;

  awt_status_e rd_st_q;
  logic        rd_vld_q;
  awt_data_t   rd_dat_q;

  // status entries read as free until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (st_we_i) begin
      vld_q[addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we_i) begin
      st_mem[addr_i] <= st_wdata_i;
    end
    if (dat_we_i) begin
      dat_mem[addr_i] <= dat_wdata_i;
    end
    if (rd_en_i) begin
      rd_st_q  <= st_mem[addr_i];
      rd_vld_q <= vld_q[addr_i];
      rd_dat_q <= dat_mem[addr_i];
    end
  end

  always_comb begin
    rd_o.status = rd_vld_q ? rd_st_q : ST_FREE;
    rd_o.data   = rd_dat_q;
  end

endmodule

// ===== design/arq_send_window_tracker.sv =====
// ----------------------------------------------------------------------------
// arq_send_window_tracker
// Sender side of a selective-repeat window: enqueue, ack, bad report, tick
// and scan items; a scan retires acked head segments, orders transmits and requeues timed-out sent segments.
// ----------------------------------------------------------------------------
//   channel   direction  handshake             payload
//   in        input      in_valid_i/in_stall_o   awt_in_t  in_item_i
//   out       output     out_valid_o/out_stall_i awt_out_t out_item_o
//   cfg       input      apb psel/penable/pwrite resend_interval at 0x0
//
// enqueue, ack, bad report and tick items are handled without leaving the idle state.
// after a scan is taken the input stays stalled while acked head segments are
// read and retired, then each segment left in the window is read and evaluated,
// all through the single slot memory port; output stalls extend it.
// reset clears status valid bits at once, no clearing pass.
// input is stalled while a scan runs or the output register is held.
// ----------------------------------------------------------------------------
module arq_send_window_tracker #(
  parameter int unsigned WINDOW_SLOTS = awt_pkg::WindowSlotsDef,
  parameter int unsigned MAX_SEGMENT  = awt_pkg::MaxSegmentDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  awt_pkg::awt_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output awt_pkg::awt_out_t out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import awt_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int unsigned CNT_W  = $clog2(WINDOW_SLOTS + 1);
  localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(WINDOW_SLOTS - 1);
  localparam logic [SLOT_W:0]   SlotsW   = (SLOT_W + 1)'(WINDOW_SLOTS);
  localparam logic [16:0]       MaxSeg   = 17'(MAX_SEGMENT);
  localparam logic [OutCntW-1:0] MaxOutN = OutCntW'(MaxOut);

  awt_state_e        state_q, state_d;
  logic [31:0]       bottom_q, bottom_d, top_q, top_d, now_q, now_d;
  logic [SLOT_W-1:0] b1_slot_q, b1_slot_d, t1_slot_q, t1_slot_d;
  logic [SLOT_W-1:0] cur_slot_q, cur_slot_d;
  logic [31:0]       cur_ser_q, cur_ser_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [OutCntW-1:0] n_q, n_d;
  logic              pend_valid_q, pend_valid_d;
  awt_out_t          pend_q, pend_d;
  logic              out_valid_q;
  awt_out_t          out_q;
  logic [15:0]       interval_q;

  logic              push_en;
  awt_out_t          push_item;
  logic              can_push;

  logic [SLOT_W-1:0] mem_addr;
  logic              mem_rd_en, mem_st_we, mem_dat_we;
  awt_status_e       mem_st_wdata;
  awt_data_t         mem_dat_wdata;
  awt_slot_t         mem_rd;

  logic [31:0]       span32, off32, age;
  logic [CNT_W-1:0]  span_n;
  logic              in_win, full;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] ack_slot;
  logic [9:0]        size_sat;

  function automatic logic [SLOT_W-1:0] adv_slot(input logic [SLOT_W-1:0] slot,
                                                 input logic [31:0] ser);
    if (ser == '1) begin
      return '0;
    end else if (slot == LastSlot) begin
      return '0;
    end else begin
      return slot + 1'b1;
    end
  endfunction

  awt_slot_store #(
    .WINDOW_SLOTS(WINDOW_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .addr_i     (mem_addr),
    .rd_en_i    (mem_rd_en),
    .st_we_i    (mem_st_we),
    .st_wdata_i (mem_st_wdata),
    .dat_we_i   (mem_dat_we),
    .dat_wdata_i(mem_dat_wdata),
    .rd_o       (mem_rd)
  );

  // config port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, interval_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= ResendReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      interval_q <= pwdata[15:0];
    end
  end

  // window arithmetic
  assign span32   = top_q - bottom_q;
  assign span_n   = span32[CNT_W-1:0];
  assign full     = span32 >= 32'(WINDOW_SLOTS);
  assign off32    = in_item_i.serial - bottom_q - 32'd1;
  assign in_win   = off32 < span32;
  assign slot_sum = {1'b0, b1_slot_q} + {1'b0, off32[SLOT_W-1:0]};
  assign age      = now_q - mem_rd.data.stamp;
  assign size_sat = (17'(in_item_i.seg_size) > MaxSeg) ? MaxSeg[9:0]
                                                         : in_item_i.seg_size;

  always_comb begin
    if (in_item_i.serial < off32) begin
      ack_slot = in_item_i.serial[SLOT_W-1:0];
    end else if (slot_sum >= SlotsW) begin
      ack_slot = SLOT_W'(slot_sum - SlotsW);
    end else begin
      ack_slot = slot_sum[SLOT_W-1:0];
    end
  end

  assign can_push   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !can_push;

  always_comb begin
    state_d       = state_q;
    bottom_d      = bottom_q;
    top_d         = top_q;
    now_d         = now_q;
    b1_slot_d     = b1_slot_q;
    t1_slot_d     = t1_slot_q;
    cur_slot_d    = cur_slot_q;
    cur_ser_d     = cur_ser_q;
    cnt_d         = cnt_q;
    n_d           = n_q;
    pend_valid_d  = pend_valid_q;
    pend_d        = pend_q;
    push_en       = 1'b0;
    push_item     = pend_q;
    mem_addr      = cur_slot_q;
    mem_rd_en     = 1'b0;
    mem_st_we     = 1'b0;
    mem_st_wdata  = ST_FREE;
    mem_dat_we    = 1'b0;
    mem_dat_wdata = mem_rd.data;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          unique case (in_item_i.req_type)
            REQ_ENQ: begin
              push_en = 1'b1;
              if (full) begin
                push_item = '{resp_kind: RESP_REFUSE, out_serial: '0,
                              out_size: '0, last: 1'b1};
              end else begin
                mem_addr      = t1_slot_q;
                mem_st_we     = 1'b1;
                mem_st_wdata  = ST_WAIT;
                mem_dat_we    = 1'b1;
                mem_dat_wdata = '{size: size_sat, stamp: now_q};
                top_d         = top_q + 32'd1;
                t1_slot_d     = adv_slot(t1_slot_q, top_q + 32'd1);
                push_item = '{resp_kind: RESP_ACCEPT, out_serial: top_q + 32'd1,
                              out_size: '0, last: 1'b1};
              end
            end
            REQ_ACK, REQ_BAD: begin
              if (in_win) begin
                mem_addr     = ack_slot;
                mem_st_we    = 1'b1;
                mem_st_wdata = (in_item_i.req_type == REQ_ACK) ? ST_ACKED : ST_WAIT;
              end
            end
            REQ_TICK: now_d = now_q + 32'd1;
            REQ_SCAN: state_d = S_RET_RD;
            default: ;
          endcase
        end
      end
      S_RET_RD: begin
        if (bottom_q == top_q) begin
          cur_slot_d = b1_slot_q;
          cur_ser_d  = bottom_q + 32'd1;
          cnt_d      = '0;
          n_d        = '0;
          state_d    = S_SCAN_RD;
        end else begin
          mem_addr  = b1_slot_q;
          mem_rd_en = 1'b1;
          state_d   = S_RET_EV;
        end
      end
      S_RET_EV: begin
        if (mem_rd.status == ST_ACKED) begin
          mem_addr     = b1_slot_q;
          mem_st_we    = 1'b1;
          mem_st_wdata = ST_FREE;
          bottom_d     = bottom_q + 32'd1;
          b1_slot_d    = adv_slot(b1_slot_q, bottom_q + 32'd1);
          state_d      = S_RET_RD;
        end else begin
          cur_slot_d = b1_slot_q;
          cur_ser_d  = bottom_q + 32'd1;
          cnt_d      = '0;
          n_d        = '0;
          state_d    = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (cnt_q == span_n) begin
          state_d = S_FLUSH;
        end else begin
          mem_rd_en = 1'b1;
          state_d   = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (mem_rd.status == ST_WAIT && n_q < MaxOutN && pend_valid_q && !can_push) begin
          state_d = S_SCAN_EV;
        end else begin
          if (mem_rd.status == ST_WAIT && n_q < MaxOutN) begin
            push_en       = pend_valid_q;
            pend_valid_d  = 1'b1;
            pend_d        = '{resp_kind: RESP_TX, out_serial: cur_ser_q,
                              out_size: mem_rd.data.size, last: 1'b0};
            n_d           = n_q + 1'b1;
            mem_st_we     = 1'b1;
            mem_st_wdata  = ST_SENT;
            mem_dat_we    = 1'b1;
            mem_dat_wdata = '{size: mem_rd.data.size, stamp: now_q};
          end else if (mem_rd.status == ST_SENT && age > {16'd0, interval_q}) begin
            mem_st_we    = 1'b1;
            mem_st_wdata = ST_WAIT;
          end
          cur_slot_d = adv_slot(cur_slot_q, cur_ser_q);
          cur_ser_d  = cur_ser_q + 32'd1;
          cnt_d      = cnt_q + 1'b1;
          state_d    = S_SCAN_RD;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (can_push) begin
          push_en        = 1'b1;
          push_item.last = 1'b1;
          pend_valid_d   = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bottom_q     <= '0;
      top_q        <= '0;
      now_q        <= '0;
      b1_slot_q    <= SLOT_W'(1);
      t1_slot_q    <= SLOT_W'(1);
      cur_slot_q   <= '0;
      cur_ser_q    <= '0;
      cnt_q        <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bottom_q     <= bottom_d;
      top_q        <= top_d;
      now_q        <= now_d;
      b1_slot_q    <= b1_slot_d;
      t1_slot_q    <= t1_slot_d;
      cur_slot_q   <= cur_slot_d;
      cur_ser_q    <= cur_ser_d;
      cnt_q        <= cnt_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      if (push_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (push_en) begin
      out_q <= push_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
